>>> sv/preemptive_priority_scheduler_top_macros.svh
// assertion macros for the scheduler
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define PPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`define PPS_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error(msg);
`else
`define PPS_ASSERT(lbl, prop, msg)
`define PPS_ASSERT_NEVER(lbl, prop, msg)
`endif

`endif

>>> sv/pps_pkg.sv
`timescale 1ns / 1ps
package pps_pkg;

  localparam int unsigned TimeW       = 16;
  localparam int unsigned PrioW       = 8;
  localparam int unsigned SlotW       = 4;
  localparam int unsigned MaxTasksDef = 16;

  localparam logic [TimeW-1:0] TimeMax = '1;

  localparam logic OpLoad = 1'b0;
  localparam logic OpTick = 1'b1;

  typedef struct packed {
    logic [TimeW-1:0] arrival;
    logic [PrioW-1:0] prio;
    logic [TimeW-1:0] burst;
    logic [TimeW-1:0] remaining;
  } entry_t;

  typedef struct packed {
    logic [TimeW-1:0] now_time;
    logic             ran;
    logic [SlotW-1:0] run_slot;
    logic             switched;
    logic             first_run;
    logic [TimeW-1:0] resp_time;
    logic             finished;
    logic [TimeW-1:0] wait_time;
    logic [TimeW-1:0] turnaround;
  } res_t;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDrain,
    StFetch,
    StUpdate
  } state_e;

endpackage

>>> sv/pps_table.sv
`timescale 1ns / 1ps
module pps_table #(
  parameter int unsigned Depth = pps_pkg::MaxTasksDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  pps_pkg::entry_t      wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  output pps_pkg::entry_t      rd_data_o
);
  import pps_pkg::*;

  entry_t mem_q [Depth];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/preemptive_priority_scheduler_top.sv
`timescale 1ns / 1ps
// channel | dir | handshake              | payload
// in      | in  | in_valid_i/in_ready_o  | opcode, slot, arrival, prio, burst
// out     | out | out_valid_o/out_ready_i| now_time .. turnaround, one beat per tick
//
// a load beat writes its slot directly; a slot of MaxTasks or above is ignored
// a tick beat runs one table read and one priority compare per slot, then a
// drain, a fetch and an update
// in_ready_o is low while a tick is in flight; the update waits while the
// previous result beat is still unaccepted in the output register
// reset clears flags, time and the last running slot; table contents are not reset
module preemptive_priority_scheduler_top #(
  parameter int unsigned MaxTasks = pps_pkg::MaxTasksDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      opcode_i,
  input  logic [pps_pkg::SlotW-1:0] slot_i,
  input  logic [pps_pkg::TimeW-1:0] arrival_i,
  input  logic [pps_pkg::PrioW-1:0] prio_i,
  input  logic [pps_pkg::TimeW-1:0] burst_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [pps_pkg::TimeW-1:0] now_time_o,
  output logic                      ran_o,
  output logic [pps_pkg::SlotW-1:0] run_slot_o,
  output logic                      switched_o,
  output logic                      first_run_o,
  output logic [pps_pkg::TimeW-1:0] resp_time_o,
  output logic                      finished_o,
  output logic [pps_pkg::TimeW-1:0] wait_time_o,
  output logic [pps_pkg::TimeW-1:0] turnaround_o
);
  import pps_pkg::*;

  `include "preemptive_priority_scheduler_top_macros.svh"

  localparam int unsigned IdxW  = $clog2(MaxTasks);
  localparam int unsigned LastW = $clog2(MaxTasks + 1);

  state_e state_q, state_d;

  logic [MaxTasks-1:0] valid_q, valid_d;
  logic [MaxTasks-1:0] done_q, done_d;
  logic [MaxTasks-1:0] started_q, started_d;
  logic [TimeW-1:0]    time_q, time_d;
  logic [LastW-1:0]    last_q, last_d;

  logic [IdxW-1:0]     idx_q, idx_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]     cmp_idx_q, cmp_idx_d;
  logic                found_q, found_d;
  logic [PrioW-1:0]    best_q, best_d;
  logic [IdxW-1:0]     pick_q, pick_d;

  logic                out_valid_q, out_valid_d;
  res_t                res_q, res_d;

  logic                wr_en;
  logic [IdxW-1:0]     wr_addr;
  entry_t              wr_data;
  logic                rd_en;
  logic [IdxW-1:0]     rd_addr;
  entry_t              rd_data;

  logic                upd_go;
  logic [IdxW-1:0]     load_addr;
  logic                slot_ok;
  logic                elig;
  logic [TimeW-1:0]    rem_n;
  logic [TimeW:0]      turn_raw;
  logic [TimeW+1:0]    wait_raw;

  pps_table #(
    .Depth (MaxTasks)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign load_addr = IdxW'(slot_i);
  assign slot_ok   = int'(slot_i) < MaxTasks;
  assign upd_go    = (state_q == StUpdate) && (!out_valid_q || out_ready_i);
  assign elig      = cmp_vld_q && valid_q[cmp_idx_q] && !done_q[cmp_idx_q]
                     && (rd_data.arrival <= time_q);
  assign rem_n     = (rd_data.remaining != '0) ? rd_data.remaining - 1'b1 : '0;
  assign turn_raw  = {1'b0, time_q} + 1'b1 - {1'b0, rd_data.arrival};
  assign wait_raw  = {1'b0, turn_raw} - {2'b00, rd_data.burst};

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    done_d      = done_q;
    started_d   = started_q;
    time_d      = time_q;
    last_d      = last_q;
    idx_d       = idx_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    best_d      = best_q;
    pick_d      = pick_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = load_addr;
    wr_data     = '{arrival: arrival_i, prio: prio_i, burst: burst_i, remaining: burst_i};
    rd_en       = 1'b0;
    rd_addr     = idx_q;

    // shared compare unit
    if (elig && (!found_q || rd_data.prio < best_q)) begin
      found_d = 1'b1;
      best_d  = rd_data.prio;
      pick_d  = cmp_idx_q;
    end

    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (opcode_i == OpLoad) begin
            if (slot_ok) begin
              wr_en                = 1'b1;
              valid_d[load_addr]   = 1'b1;
              done_d[load_addr]    = 1'b0;
              started_d[load_addr] = 1'b0;
            end
          end else begin
            idx_d   = '0;
            found_d = 1'b0;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        rd_en     = 1'b1;
        rd_addr   = idx_q;
        cmp_vld_d = 1'b1;
        cmp_idx_d = idx_q;
        if (idx_q == IdxW'(MaxTasks - 1)) begin
          state_d = StDrain;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StDrain: begin
        state_d = StFetch;
      end
      StFetch: begin
        rd_en   = 1'b1;
        rd_addr = pick_q;
        state_d = StUpdate;
      end
      StUpdate: begin
        if (upd_go) begin
          out_valid_d  = 1'b1;
          res_d        = '0;
          res_d.now_time = time_q;
          if (found_q) begin
            res_d.ran      = 1'b1;
            res_d.run_slot = SlotW'(pick_q);
            res_d.switched = LastW'(pick_q) != last_q;
            last_d         = LastW'(pick_q);
            if (!started_q[pick_q]) begin
              started_d[pick_q] = 1'b1;
              res_d.first_run   = 1'b1;
              res_d.resp_time   = time_q - rd_data.arrival;
            end
            wr_en             = 1'b1;
            wr_addr           = pick_q;
            wr_data           = rd_data;
            wr_data.remaining = rem_n;
            if (rem_n == '0) begin
              done_d[pick_q]   = 1'b1;
              res_d.finished   = 1'b1;
              res_d.turnaround = turn_raw[TimeW] ? TimeMax : turn_raw[TimeW-1:0];
              if (wait_raw[TimeW+1]) begin
                res_d.wait_time = '0;
              end else if (wait_raw[TimeW]) begin
                res_d.wait_time = TimeMax;
              end else begin
                res_d.wait_time = wait_raw[TimeW-1:0];
              end
            end
          end else begin
            last_d = LastW'(MaxTasks);
          end
          if (time_q != TimeMax) begin
            time_d = time_q + 1'b1;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      done_q      <= '0;
      started_q   <= '0;
      time_q      <= '0;
      last_q      <= LastW'(MaxTasks);
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      done_q      <= done_d;
      started_q   <= started_d;
      time_q      <= time_d;
      last_q      <= last_d;
      idx_q       <= idx_d;
      cmp_vld_q   <= cmp_vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    best_q    <= best_d;
    pick_q    <= pick_d;
    res_q     <= res_d;
  end

  assign out_valid_o  = out_valid_q;
  assign now_time_o   = res_q.now_time;
  assign ran_o        = res_q.ran;
  assign run_slot_o   = res_q.run_slot;
  assign switched_o   = res_q.switched;
  assign first_run_o  = res_q.first_run;
  assign resp_time_o  = res_q.resp_time;
  assign finished_o   = res_q.finished;
  assign wait_time_o  = res_q.wait_time;
  assign turnaround_o = res_q.turnaround;

  `PPS_ASSERT(a_done_loaded, (done_q & ~valid_q) == '0, "done flag on unloaded slot")
  `PPS_ASSERT(a_started_loaded, (started_q & ~valid_q) == '0, "started flag on unloaded slot")
  `PPS_ASSERT_NEVER(a_idle_tick, out_valid_q && !res_q.ran && (res_q.switched || res_q.first_run || res_q.finished), "idle tick reports a task event")
  `PPS_ASSERT(a_wait_le_turn, out_valid_q && res_q.finished |-> res_q.turnaround >= res_q.wait_time, "wait time above turnaround")
  `PPS_ASSERT(a_time_step, upd_go |=> (time_q == $past(time_q) + 16'd1) || (time_q == TimeMax), "time did not advance")

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import pps_pkg::*;

  localparam int NumSlots    = MaxTasksDef;
  localparam int NoTask      = NumSlots;
  localparam int HoldCycles  = 300;
  localparam int StallLimit  = 4000;
  localparam int DrainCycles = 40;
  localparam int PhaseItems  = 250;

  typedef struct {
    logic             op;
    logic [SlotW-1:0] slot;
    logic [TimeW-1:0] arrival;
    logic [PrioW-1:0] prio;
    logic [TimeW-1:0] burst;
  } beat_t;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  logic             opcode    = OpLoad;
  logic [SlotW-1:0] slot      = '0;
  logic [TimeW-1:0] arrival   = '0;
  logic [PrioW-1:0] prio      = '0;
  logic [TimeW-1:0] burst     = '0;
  logic             out_ready = 1'b0;

  logic             in_ready_o;
  logic             out_valid_o;
  logic [TimeW-1:0] now_time_o;
  logic             ran_o;
  logic [SlotW-1:0] run_slot_o;
  logic             switched_o;
  logic             first_run_o;
  logic [TimeW-1:0] resp_time_o;
  logic             finished_o;
  logic [TimeW-1:0] wait_time_o;
  logic [TimeW-1:0] turnaround_o;

  // scheduler state as seen by the predictor
  logic [TimeW-1:0] task_arrival   [NumSlots];
  logic [PrioW-1:0] task_prio      [NumSlots];
  logic [TimeW-1:0] task_burst     [NumSlots];
  logic [TimeW-1:0] task_remaining [NumSlots];
  bit               task_loaded    [NumSlots];
  bit               task_done      [NumSlots];
  bit               task_started   [NumSlots];
  logic [TimeW-1:0] sched_time = '0;
  int               last_run   = NoTask;

  beat_t pending_beats[$];
  res_t  tick_results_q[$];
  beat_t nxt;

  int err_cnt       = 0;
  int gen_time      = 0;
  int send_idle_pct = 31;
  int recv_idle_pct = 80;
  bit hold_arm      = 1'b0;
  bit hold_done;
  int hold_left;
  int quiet_cycles  = 0;

  preemptive_priority_scheduler_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode),
    .slot_i       (slot),
    .arrival_i    (arrival),
    .prio_i       (prio),
    .burst_i      (burst),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .now_time_o   (now_time_o),
    .ran_o        (ran_o),
    .run_slot_o   (run_slot_o),
    .switched_o   (switched_o),
    .first_run_o  (first_run_o),
    .resp_time_o  (resp_time_o),
    .finished_o   (finished_o),
    .wait_time_o  (wait_time_o),
    .turnaround_o (turnaround_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [TimeW-1:0] clamp_time(input longint v);
    if (v < 0) return '0;
    if (v > longint'(TimeMax)) return TimeMax;
    return v[TimeW-1:0];
  endfunction

  task automatic report_error(input string msg);
    err_cnt++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [TimeW-1:0] got,
                             input logic [TimeW-1:0] want);
    if (got !== want)
      report_error($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // apply one accepted beat to the scheduler state, queue the tick result
  task automatic sched_step(input logic op, input logic [SlotW-1:0] sl,
                            input logic [TimeW-1:0] arr, input logic [PrioW-1:0] pr,
                            input logic [TimeW-1:0] bu);
    res_t             r;
    bit               found;
    int               pick;
    logic [PrioW-1:0] best;
    if (op == OpLoad) begin
      if (int'(sl) < NumSlots) begin
        task_arrival[sl]   = arr;
        task_prio[sl]      = pr;
        task_burst[sl]     = bu;
        task_remaining[sl] = bu;
        task_loaded[sl]    = 1'b1;
        task_done[sl]      = 1'b0;
        task_started[sl]   = 1'b0;
      end
      return;
    end
    r = '0;
    r.now_time = sched_time;
    found = 1'b0;
    pick = 0;
    best = '0;
    for (int s = 0; s < NumSlots; s++) begin
      if (task_loaded[s] && !task_done[s] && task_arrival[s] <= sched_time) begin
        if (!found || task_prio[s] < best) begin
          found = 1'b1;
          best = task_prio[s];
          pick = s;
        end
      end
    end
    if (!found) begin
      last_run = NoTask;
    end else begin
      r.ran = 1'b1;
      r.run_slot = pick[SlotW-1:0];
      r.switched = (pick != last_run);
      last_run = pick;
      if (!task_started[pick]) begin
        task_started[pick] = 1'b1;
        r.first_run = 1'b1;
        r.resp_time = clamp_time(longint'(sched_time) - longint'(task_arrival[pick]));
      end
      if (task_remaining[pick] != 0) task_remaining[pick]--;
      if (task_remaining[pick] == 0) begin
        task_done[pick] = 1'b1;
        r.finished = 1'b1;
        r.wait_time = clamp_time(longint'(sched_time) + 1 - longint'(task_burst[pick])
                                 - longint'(task_arrival[pick]));
        r.turnaround = clamp_time(longint'(sched_time) + 1 - longint'(task_arrival[pick]));
      end
    end
    tick_results_q.push_back(r);
    if (sched_time != TimeMax) sched_time++;
  endtask

  task automatic check_beat();
    res_t want;
    if (tick_results_q.size() == 0) begin
      report_error("result beat with no tick outstanding");
      return;
    end
    want = tick_results_q.pop_front();
    check_field("now_time", now_time_o, want.now_time);
    check_field("ran", ran_o, want.ran);
    check_field("run_slot", run_slot_o, want.run_slot);
    check_field("switched", switched_o, want.switched);
    check_field("first_run", first_run_o, want.first_run);
    check_field("resp_time", resp_time_o, want.resp_time);
    check_field("finished", finished_o, want.finished);
    check_field("wait_time", wait_time_o, want.wait_time);
    check_field("turnaround", turnaround_o, want.turnaround);
  endtask

  task automatic push_load(input int sl, input int arr, input int pr, input int bu);
    beat_t b;
    b.op = OpLoad;
    b.slot = sl[SlotW-1:0];
    b.arrival = arr[TimeW-1:0];
    b.prio = pr[PrioW-1:0];
    b.burst = bu[TimeW-1:0];
    pending_beats.push_back(b);
  endtask

  // unused fields of a tick carry noise
  task automatic push_tick();
    beat_t b;
    b.op = OpTick;
    b.slot = SlotW'($urandom_range(NumSlots - 1));
    b.arrival = TimeW'($urandom_range(65535));
    b.prio = PrioW'($urandom_range(255));
    b.burst = TimeW'($urandom_range(65535));
    pending_beats.push_back(b);
    if (gen_time < 65535) gen_time++;
  endtask

  task automatic push_random(input int n);
    int a;
    int pr;
    int bu;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 25) begin
        if ($urandom_range(9) == 0) begin
          a = $urandom_range(65535);
        end else begin
          a = gen_time + int'($urandom_range(8)) - 3;
          if (a < 0) a = 0;
        end
        pr = ($urandom_range(1) == 0) ? $urandom_range(7) : $urandom_range(255);
        bu = $urandom_range(6, 1);
        // long tasks mostly sit at the bottom of the order
        if ($urandom_range(99) < 8) begin
          bu = $urandom_range(65535, 1);
          pr = $urandom_range(255, 192);
        end
        push_load($urandom_range(NumSlots - 1), a, pr, bu);
      end else begin
        push_tick();
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid || tick_results_q.size() != 0)
      @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      opcode <= OpLoad;
      slot <= '0;
      arrival <= '0;
      prio <= '0;
      burst <= '0;
    end else begin
      if (in_valid && in_ready_o) sched_step(opcode, slot, arrival, prio, burst);
      if (!in_valid || in_ready_o) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_beats.pop_front();
          in_valid <= 1'b1;
          opcode <= nxt.op;
          slot <= nxt.slot;
          arrival <= nxt.arrival;
          prio <= nxt.prio;
          burst <= nxt.burst;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) check_beat();
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_arm && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // idle tick straight after reset, then a short run to completion
    push_tick();
    push_load(0, 0, 0, 2);
    repeat (3) push_tick();
    // tie on priority goes to the lower slot, slot 2 preempts on arrival
    push_load(3, gen_time, 5, 3);
    push_load(1, gen_time, 5, 1);
    push_load(2, gen_time + 2, 1, 2);
    repeat (6) push_tick();
    // zero burst still runs once
    push_load(5, gen_time, 0, 0);
    push_tick();
    push_load(15, 65535, 0, 65535);
    push_load(14, 0, 255, 65535);
    push_load(6, gen_time, 2, 4);
    repeat (2) push_tick();
    // reload of a running slot restarts it
    push_load(6, gen_time, 2, 1);
    repeat (2) push_tick();
    push_random(PhaseItems);
    wait_idle();

    @(negedge clk_i);
    send_idle_pct = 80;
    recv_idle_pct = 31;
    push_random(PhaseItems);
    wait_idle();

    @(negedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_arm = 1'b1;
    push_random(PhaseItems);
    wait_idle();

    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/pps_pkg.sv
sv/pps_table.sv
sv/preemptive_priority_scheduler_top.sv
verif/testbench.sv
